### rtl/vtb_pkg.sv
// Shared types and constants for the virtual timer bank.
`default_nettype none

package vtb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int POS_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int DELAY_W     = 32;
    localparam int HANDLE_W    = 8;
    localparam int SLOT_W      = 3;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SCHEDULE = 1'b1;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [1:0] {
        VTB_IDLE,
        VTB_SCAN,
        VTB_DONE
    } vtb_state_t;

    // Controller to every cell.
    typedef struct packed {
        logic                shift;
        logic                start;
        logic                cmd;
        logic [DELAY_W-1:0]  delay;
        logic [HANDLE_W-1:0] handle;
    } vtb_bcast_t;

    // Chain back to controller.
    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] action;
        logic                tok_last;
        logic                found_last;
    } vtb_stat_t;

endpackage

`default_nettype wire

### rtl/vtb_if.sv
// Request and response channel interfaces of the virtual timer bank.
`default_nettype none

interface vtb_req_if;
    import vtb_pkg::*;
    logic                valid;
    logic                ready;
    logic                command;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, command, delay, handle, input ready);
    modport sink   (input valid, command, delay, handle, output ready);
endinterface

interface vtb_rsp_if;
    import vtb_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic                accepted;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] action;
    logic                last;

    modport source (output valid, kind, accepted, slot, action, last, input ready);
    modport sink   (input valid, kind, accepted, slot, action, last, output ready);
endinterface

`default_nettype wire

### rtl/vtb_cell.sv
// One timer slot: countdown, handle, and the travelling scan token.
`default_nettype none

module vtb_cell
    import vtb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vtb_bcast_t          bcast,
    input  wire logic                tok_in,
    input  wire logic                found_in,
    output logic                     tok_out,
    output logic                     found_out,
    output logic                     hit,
    output logic [HANDLE_W-1:0]      action
);

    logic [DELAY_W-1:0]  rem_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                token_reg;
    logic                found_reg;
    logic                sched_hit;
    logic                tick_hit;

    assign tick_hit  = token_reg && (bcast.cmd == CMD_TICK) && (rem_reg == DELAY_W'(1));
    assign sched_hit = token_reg && (bcast.cmd == CMD_SCHEDULE) && !found_reg
                       && (rem_reg == '0);
    assign hit       = tick_hit || sched_hit;
    assign action    = tick_hit ? handle_reg : '0;
    assign tok_out   = token_reg;
    assign found_out = found_reg || sched_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            token_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (bcast.shift)
        begin
            token_reg <= tok_in;
            found_reg <= found_in;
            if (token_reg && (bcast.cmd == CMD_TICK) && (rem_reg != '0))
            begin
                rem_reg <= rem_reg - DELAY_W'(1);
            end
            else if (sched_hit)
            begin
                rem_reg <= bcast.delay;
            end
        end
    end

    // handle store: no reset, written on a successful schedule
    always_ff @(posedge clk)
    begin
        if (bcast.shift && sched_hit)
        begin
            handle_reg <= bcast.handle;
        end
    end

endmodule

`default_nettype wire

### rtl/vtb_ctrl.sv
// Scan sequencer, result hold stage and output register.
`default_nettype none

module vtb_ctrl
    import vtb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    vtb_req_if.sink       req,
    vtb_rsp_if.source     rsp,
    output vtb_bcast_t    bcast,
    input  wire vtb_stat_t stat
);

    vtb_state_t          state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                found_reg, found_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [HANDLE_W-1:0] pend_action_reg, pend_action_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic                out_acc_reg, out_acc_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [HANDLE_W-1:0] out_action_reg, out_action_next;
    logic                out_last_reg, out_last_next;

    logic accept;
    logic out_free;
    logic scan_step;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == VTB_IDLE);
    assign accept    = req.valid && req.ready;
    assign scan_step = (state_reg == VTB_SCAN) && out_free;

    assign bcast.shift  = accept || scan_step;
    assign bcast.start  = accept;
    assign bcast.cmd    = cmd_reg;
    assign bcast.delay  = delay_reg;
    assign bcast.handle = handle_reg;

    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.accepted = out_acc_reg;
    assign rsp.slot     = out_slot_reg;
    assign rsp.action   = out_action_reg;
    assign rsp.last     = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            VTB_IDLE: if (accept) state_next = VTB_SCAN;
            VTB_SCAN: if (scan_step && stat.tok_last) state_next = VTB_DONE;
            VTB_DONE: if (out_free) state_next = VTB_IDLE;
            default:  state_next = VTB_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next         = cmd_reg;
        delay_next       = delay_reg;
        handle_next      = handle_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_action_next = pend_action_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_acc_next     = out_acc_reg;
        out_slot_next    = out_slot_reg;
        out_action_next  = out_action_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            VTB_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.command;
                    delay_next  = req.delay;
                    handle_next = req.handle;
                    pos_next    = '0;
                    found_next  = 1'b0;
                end
            end
            VTB_SCAN:
            begin
                if (scan_step)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (stat.tok_last)
                    begin
                        found_next = stat.found_last;
                    end
                    if (stat.hit && (cmd_reg == CMD_SCHEDULE))
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_REPLY;
                        out_acc_next    = 1'b1;
                        out_slot_next   = SLOT_W'(pos_reg);
                        out_action_next = '0;
                        out_last_next   = 1'b1;
                    end
                    else if (stat.hit)
                    begin
                        // earlier expiry is not the last one: release it
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_EXPIRY;
                            out_acc_next    = 1'b1;
                            out_slot_next   = pend_slot_reg;
                            out_action_next = pend_action_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_slot_next   = SLOT_W'(pos_reg);
                        pend_action_next = stat.action;
                    end
                end
            end
            VTB_DONE:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_EXPIRY;
                        out_acc_next    = 1'b1;
                        out_slot_next   = pend_slot_reg;
                        out_action_next = pend_action_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    else if ((cmd_reg == CMD_SCHEDULE) && !found_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_REPLY;
                        out_acc_next    = 1'b0;
                        out_slot_next   = '0;
                        out_action_next = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= VTB_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        delay_reg       <= delay_next;
        handle_reg      <= handle_next;
        pos_reg         <= pos_next;
        found_reg       <= found_next;
        pend_slot_reg   <= pend_slot_next;
        pend_action_reg <= pend_action_next;
        out_kind_reg    <= out_kind_next;
        out_acc_reg     <= out_acc_next;
        out_slot_reg    <= out_slot_next;
        out_action_reg  <= out_action_next;
        out_last_reg    <= out_last_next;
    end

endmodule

`default_nettype wire

### rtl/virtual_timer_bank.sv
// Virtual timer bank top level: slot cell chain plus sequencer.
//
// Usage:
//  req channel carries transactions with command (tick or schedule), delay and
//  handle. rsp channel returns results: kind, accepted, slot, action, last.
//  A schedule yields exactly one reply (last set); a tick yields one expiry
//  per slot whose count reaches zero, ascending by slot, the final one with
//  last set, or nothing if no slot expires.
//  Timing: a token walks the cell chain one slot per cycle while rsp is not
//  stalled; each request passes through one load step, TIMER_COUNT scan
//  steps and one closing step. When the first result appears depends on
//  the slot that reports it.
//  req.ready is high only while idle, not during the scan or closing step; a result still
//  sitting in the output register does not hold off a new request.
//  Stall: while rsp.ready is low with a result waiting, the scan freezes in
//  place and resumes once the result is taken; nothing is lost or repeated.
//  Reset: all counts clear (every slot free), no token, no result pending.
//  Stored handles are not cleared; they are written on each accepted schedule.
`default_nettype none

module virtual_timer_bank
    import vtb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vtb_req_if.sink   req,
    vtb_rsp_if.source rsp
);

    vtb_bcast_t          bcast;
    vtb_stat_t           stat;
    logic [TIMER_COUNT:0] tok_chain;
    logic [TIMER_COUNT:0] found_chain;
    logic [TIMER_COUNT-1:0] cell_hit;
    logic [HANDLE_W-1:0] cell_action [TIMER_COUNT];
    logic                any_hit;
    logic [HANDLE_W-1:0] any_action;

    // token enters slot 0 on acceptance; nothing placed yet
    assign tok_chain[0]   = bcast.start;
    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < TIMER_COUNT; g++)
    begin : g_cell
        vtb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .tok_in    (tok_chain[g]),
            .found_in  (found_chain[g]),
            .tok_out   (tok_chain[g+1]),
            .found_out (found_chain[g+1]),
            .hit       (cell_hit[g]),
            .action    (cell_action[g])
        );
    end

    // only the token holder can report, so an OR gathers its result
    always_comb
    begin
        any_hit    = 1'b0;
        any_action = '0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            any_hit    = any_hit | cell_hit[i];
            any_action = any_action | cell_action[i];
        end
    end

    assign stat.hit        = any_hit;
    assign stat.action     = any_action;
    assign stat.tok_last   = tok_chain[TIMER_COUNT];
    assign stat.found_last = found_chain[TIMER_COUNT];

    vtb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .bcast (bcast),
        .stat  (stat)
    );

endmodule

`default_nettype wire

### rtl/vtb_checker.sv
// Port-level assertions for the virtual timer bank, with bind.
`default_nettype none

module vtb_checker
    import vtb_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic                rsp_kind,
    input wire logic                rsp_accepted,
    input wire logic [SLOT_W-1:0]   rsp_slot,
    input wire logic [HANDLE_W-1:0] rsp_action,
    input wire logic                rsp_last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_slot) && $stable(rsp_action) && $stable(rsp_last))
        else $error("stalled result changed");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_REPLY) |-> rsp_last && (rsp_action == '0))
        else $error("schedule reply not single or carries an action");

    a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_REPLY) && !rsp_accepted |-> (rsp_slot == '0))
        else $error("rejected reply names a slot");

    a_expiry_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_EXPIRY) |-> rsp_accepted)
        else $error("expiry report not marked accepted");

endmodule

bind virtual_timer_bank vtb_checker u_vtb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_accepted (rsp.accepted),
    .rsp_slot     (rsp.slot),
    .rsp_action   (rsp.action),
    .rsp_last     (rsp.last)
);

`default_nettype wire
